/* sv/ort_pkg.sv */
// Shared types and codes for the ordered record table.
package ort_pkg;

  // Command codes carried in the action field.
  localparam logic [2:0] ACT_INSERT   = 3'd0;
  localparam logic [2:0] ACT_DELETE   = 3'd1;
  localparam logic [2:0] ACT_LOCATE   = 3'd2;
  localparam logic [2:0] ACT_RETRIEVE = 3'd3;
  localparam logic [2:0] ACT_SORTED   = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_POS   = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the incoming command beat
    logic compare;  // register the per-entry compare vectors
    logic commit;   // update the table and load the result register
  } ort_cmd_t;

endpackage

/* sv/ort_ctrl.sv */
// Controller state machine for the ordered record table.
module ort_ctrl
  import ort_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ort_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   commit_ok;
  logic   take;

  // The result register can be loaded when it is empty or being drained.
  assign commit_ok  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_COMMIT) && commit_ok));
  assign take       = in_valid_i && !in_stall_o;

  assign cmd_o.latch   = take;
  assign cmd_o.compare = (state_q == S_CMP);
  assign cmd_o.commit  = (state_q == S_COMMIT) && commit_ok;
  assign out_valid_o   = out_valid_q;

  // State sequencing and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (take) state_q <= S_CMP;
        end
        S_CMP: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_ok) state_q <= take ? S_CMP : S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if ((state_q == S_COMMIT) && commit_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* sv/ort_datapath.sv */
// Entry cells, compare vectors and result register of the ordered record table.
module ort_datapath
  import ort_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ort_cmd_t           cmd_i,
  input  logic [2:0]         action_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] item_key_i,
  input  logic [7:0]         item_age_i,
  output logic [2:0]         status_o,
  output logic [3:0]         found_index_o,
  output logic signed [31:0] out_key_o,
  output logic [7:0]         out_age_o,
  output logic [4:0]         fill_level_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > 5) ? CW : 5;
  localparam logic [MW-1:0] CapM = MW'(CAPACITY);

  // Entry cells; contents are meaningful only below the entry count.
  logic signed [31:0] key_q [CAPACITY];
  logic [7:0]         age_q [CAPACITY];
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      count_d;

  // Latched command beat.
  logic [2:0]         act_q;
  logic [4:0]         pos_q;
  logic signed [31:0] ikey_q;
  logic [7:0]         iage_q;

  // Registered compare vectors.
  logic [CAPACITY-1:0] match_q;
  logic [CAPACITY-1:0] stop_q;

  // Result register.
  logic [2:0]         status_q;
  logic [3:0]         found_q;
  logic signed [31:0] okey_q;
  logic [7:0]         oage_q;
  logic [4:0]         fill_q;

  logic [2:0]         status_d;
  logic [IW-1:0]      found_d;
  logic signed [31:0] okey_d;
  logic [7:0]         oage_d;
  logic               do_ins;
  logic               do_del;
  logic [IW-1:0]      ins_pos;
  logic [IW-1:0]      match_idx;
  logic [IW-1:0]      stop_idx;
  logic [IW-1:0]      pos_idx;
  logic [MW-1:0]      pos_m;
  logic [MW-1:0]      cnt_m;

  assign pos_m   = MW'(pos_q);
  assign cnt_m   = MW'(count_q);
  assign pos_idx = IW'(pos_q);

  // Capture the command beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      pos_q  <= position_i;
      ikey_q <= item_key_i;
      iage_q <= item_age_i;
    end
  end

  // Per-entry equality and signed ordering against the command key.
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match_q[i] <= (CW'(i) < count_q) && (key_q[i] == ikey_q);
        stop_q[i]  <= !((CW'(i) < count_q) && (key_q[i] < ikey_q));
      end
    end
  end

  // First matching entry and first entry not below the key.
  always_comb begin
    match_idx = '0;
    stop_idx  = IW'(count_q);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) match_idx = IW'(i);
      if (stop_q[i])  stop_idx  = IW'(i);
    end
  end

  // Command decode and result fields.
  always_comb begin
    status_d = ST_OK;
    found_d  = '0;
    okey_d   = '0;
    oage_d   = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    ins_pos  = pos_idx;
    count_d  = count_q;
    unique case (act_q)
      ACT_INSERT: begin
        if (pos_m > cnt_m) begin
          status_d = ST_BAD_POS;
        end else if (cnt_m >= CapM) begin
          status_d = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_m >= cnt_m) begin
          status_d = ST_BAD_POS;
        end else begin
          do_del  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      ACT_LOCATE: begin
        if (|match_q) begin
          found_d = match_idx;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      ACT_RETRIEVE: begin
        if (pos_m >= cnt_m) begin
          status_d = ST_BAD_POS;
        end else begin
          okey_d = key_q[pos_idx];
          oage_d = age_q[pos_idx];
        end
      end
      ACT_SORTED: begin
        if (cnt_m >= CapM) begin
          status_d = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          ins_pos = stop_idx;
          found_d = stop_idx;
          count_d = count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Parallel shift of the entry cells on insert and delete.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins) begin
          if (IW'(i) == ins_pos) begin
            key_q[i] <= ikey_q;
            age_q[i] <= iage_q;
          end else if ((i > 0) && (IW'(i) > ins_pos)) begin
            key_q[i] <= key_q[(i > 0) ? i - 1 : 0];
            age_q[i] <= age_q[(i > 0) ? i - 1 : 0];
          end
        end else if (do_del) begin
          if ((i < CAPACITY - 1) && (IW'(i) >= pos_idx)) begin
            key_q[i] <= key_q[(i < CAPACITY - 1) ? i + 1 : i];
            age_q[i] <= age_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      found_q  <= 4'(found_d);
      okey_q   <= okey_d;
      oage_q   <= oage_d;
      fill_q   <= 5'(count_d);
    end
  end

  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign out_key_o     = okey_q;
  assign out_age_o     = oage_q;
  assign fill_level_o  = fill_q;

endmodule

/* sv/ordered_record_table.sv */
// Top level of the ordered record table.
//
// Ordered table of up to CAPACITY records (signed 32-bit key, 8-bit age).
// Each input beat carries one command: insert at position, delete at
// position, locate key, retrieve at position or sorted insert. Every
// command produces exactly one output beat with status, found index,
// retrieved record and the fill level after the command.
// Both channels use valid/stall; a beat moves when valid is high and
// stall is low. After acceptance, a command first registers the
// per-entry compare vectors, then shifts the entry cells in parallel
// and loads the result register. A new command is taken in the commit
// cycle, so the next command can be accepted before the last completes.
// The result register decouples the sides: while an output beat is
// stalled, the next command is still accepted and compared, and waits in
// its commit cycle until the result register drains.
// Reset empties the table (entry count 0); entry contents are not cleared
// and are never read before being written.
module ordered_record_table
  import ort_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] item_key_i,
  input  logic [7:0]         item_age_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [3:0]         found_index_o,
  output logic signed [31:0] out_key_o,
  output logic [7:0]         out_age_o,
  output logic [4:0]         fill_level_o
);

  ort_cmd_t cmd;

  // Sequencing.
  ort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Table storage and result.
  ort_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (action_i),
    .position_i    (position_i),
    .item_key_i    (item_key_i),
    .item_age_i    (item_age_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .out_key_o     (out_key_o),
    .out_age_o     (out_age_o),
    .fill_level_o  (fill_level_o)
  );

endmodule

/* sv/ort_checker.sv */
// Port-level checks for the ordered record table and their bind.
module ort_checker
  import ort_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         status_o,
  input logic signed [31:0] out_key_o,
  input logic [7:0]         out_age_o,
  input logic [4:0]         fill_level_o
);

  // A command is never taken in the cycle right after another one.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("command taken in compare cycle");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
      && $stable(out_key_o) && $stable(out_age_o) && $stable(fill_level_o)))
    else $error("stalled output beat changed");

  // Failed commands carry no record.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> ((out_key_o == '0) && (out_age_o == '0)))
    else $error("record returned with error status");

  // An empty-table error reports an empty fill level.
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |-> (fill_level_o == '0))
    else $error("empty status with nonzero fill level");

endmodule

bind ordered_record_table ort_checker u_ort_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .out_key_o    (out_key_o),
  .out_age_o    (out_age_o),
  .fill_level_o (fill_level_o)
);
